[rtl/core/msoic_pkg.sv]
// Shared types, codes and helpers for the scan-order to coordinate block.
// Used by the walker and the top level.
package msoic_pkg;

    localparam int POS_W   = 16;
    localparam int COORD_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_VAL_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_MODE       = 3'd0,
        REG_ROW_COUNT       = 3'd1,
        REG_COL_COUNT       = 3'd2,
        REG_START_CORNER    = 3'd3,
        REG_FIRST_DIRECTION = 3'd4
    } reg_idx_t;

    localparam logic [1:0] MODE_SNAKE       = 2'd0;
    localparam logic [1:0] MODE_SPIRAL      = 2'd1;
    localparam logic [1:0] MODE_REV_SPIRAL  = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0] position;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               out_of_range;
    } out_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } cfg_word_t;

    // Unit step: each component is -1, 0 or +1.
    typedef struct packed {
        logic signed [1:0] dr;
        logic signed [1:0] dc;
    } dir_t;

    // Walker control from the sequencer.
    typedef struct packed {
        logic load;
        logic step;
        logic spiral;
        logic rev;
        logic sense_pos;
        dir_t dir;
        logic r0_zero;
        logic c0_zero;
    } walk_ctl_t;

    // Quarter turn; sense_pos selects +1, otherwise -1.
    function automatic dir_t turn_dir(input dir_t d, input logic sense_pos);
        dir_t t;
        if (d.dc == 2'sd0)
        begin
            t.dr = 2'sd0;
            t.dc = sense_pos ? d.dr : -d.dr;
        end
        else
        begin
            t.dr = sense_pos ? -d.dc : d.dc;
            t.dc = 2'sd0;
        end
        return t;
    endfunction

endpackage

[rtl/core/msoic_chan_if.sv]
// Valid/ready channel carrying one payload word of a chosen type.
// Payload types come from msoic_pkg.
interface msoic_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/msoic_walker.sv]
// Grid walker: position, direction and spiral bounds, one step per cycle while step is set.
// Depends on msoic_pkg for the control struct and the turn helper.
module msoic_walker #(
    parameter int MAX_DIM = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  msoic_pkg::walk_ctl_t                  ctl,
    input  logic [$clog2(MAX_DIM+1)-1:0]          nr,
    input  logic [$clog2(MAX_DIM+1)-1:0]          nc,
    input  logic [$clog2(MAX_DIM+1)-1:0]          r0,
    input  logic [$clog2(MAX_DIM+1)-1:0]          c0,
    output logic [msoic_pkg::COORD_W-1:0]         row,
    output logic [msoic_pkg::COORD_W-1:0]         col
);
    import msoic_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    // Wide enough for a walk that strays 2^POS_W steps off the grid.
    localparam int CW = $clog2(MAX_DIM + (1 << POS_W)) + 2;
    localparam logic signed [CW-1:0] ONE   = 1;
    localparam logic signed [CW-1:0] ZERO  = 0;
    localparam logic signed [CW-1:0] M_ONE = -1;

    function automatic logic signed [CW-1:0] sx(input logic signed [1:0] v);
        return {{(CW-2){v[1]}}, v};
    endfunction

    logic signed [CW-1:0] r_reg, c_reg, top_reg, bot_reg, left_reg, right_reg;
    logic signed [CW-1:0] r_next, c_next, top_next, bot_next, left_next, right_next;
    dir_t                 dir_reg, dir_next;
    logic                 sense_reg, sense_next;
    logic [1:0]           turns_reg, turns_next;
    logic                 extra_reg, extra_next;

    logic signed [CW-1:0] nr_s, nc_s, rs, cs;
    dir_t                 d1, d2;
    logic                 s1, hit, off_grid;

    assign nr_s = {{(CW-DW){1'b0}}, nr};
    assign nc_s = {{(CW-DW){1'b0}}, nc};

    always_comb
    begin
        d1 = extra_reg ? turn_dir(dir_reg, sense_reg) : dir_reg;
        s1 = extra_reg ? ~sense_reg : sense_reg;
        d2 = turn_dir(d1, s1);
        rs = r_reg + sx(d1.dr);
        cs = c_reg + sx(d1.dc);
        hit = (rs == top_reg) || (rs == bot_reg) || (cs == left_reg) || (cs == right_reg);
        off_grid = (rs < ZERO) || (rs >= nr_s) || (cs < ZERO) || (cs >= nc_s);

        r_next     = r_reg;
        c_next     = c_reg;
        top_next   = top_reg;
        bot_next   = bot_reg;
        left_next  = left_reg;
        right_next = right_reg;
        dir_next   = dir_reg;
        sense_next = sense_reg;
        turns_next = turns_reg;
        extra_next = extra_reg;

        if (ctl.load)
        begin
            r_next     = {{(CW-DW){1'b0}}, r0};
            c_next     = {{(CW-DW){1'b0}}, c0};
            top_next   = M_ONE;
            left_next  = M_ONE;
            bot_next   = nr_s;
            right_next = nc_s;
            dir_next   = ctl.dir;
            sense_next = ctl.sense_pos;
            turns_next = 2'd0;
            extra_next = 1'b0;
        end
        else if (ctl.step && ctl.spiral)
        begin
            extra_next = 1'b0;
            sense_next = s1;
            dir_next   = d1;
            r_next     = rs;
            c_next     = cs;
            if (hit)
            begin
                // shrink the bound beside the line just walked, back off, turn and step again
                if (d1.dc != 2'sd0)
                begin
                    if (rs == top_reg + ONE)
                        top_next = top_reg + ONE;
                    else
                        bot_next = bot_reg - ONE;
                end
                else
                begin
                    if (cs == left_reg + ONE)
                        left_next = left_reg + ONE;
                    else
                        right_next = right_reg - ONE;
                end
                dir_next = d2;
                r_next   = r_reg + sx(d2.dr);
                c_next   = c_reg + sx(d2.dc);
                if (ctl.rev)
                begin
                    turns_next = turns_reg + 2'd1;
                    extra_next = (turns_reg == 2'd3);
                end
            end
        end
        else if (ctl.step)
        begin
            r_next = rs;
            c_next = cs;
            if (off_grid)
            begin
                // reverse and shift one line away from the start edge
                dir_next.dr = -d1.dr;
                dir_next.dc = -d1.dc;
                if (d1.dc == 2'sd0)
                begin
                    r_next = r_reg;
                    c_next = c_reg + (ctl.c0_zero ? ONE : M_ONE);
                end
                else
                begin
                    r_next = r_reg + (ctl.r0_zero ? ONE : M_ONE);
                    c_next = c_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= '0;
            sense_reg <= 1'b0;
            turns_reg <= 2'd0;
            extra_reg <= 1'b0;
        end
        else
        begin
            dir_reg   <= dir_next;
            sense_reg <= sense_next;
            turns_reg <= turns_next;
            extra_reg <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        c_reg     <= c_next;
        top_reg   <= top_next;
        bot_reg   <= bot_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    assign row = r_reg[COORD_W-1:0];
    assign col = c_reg[COORD_W-1:0];

endmodule

[rtl/core/matrix_scan_order_index_to_coord.sv]
// Scan-order position to grid row/column: snake, spiral, reversing spiral.
// Each accepted word passes through the area, check, run and finish states;
// the walker advances one grid step per cycle in the run state. Out-of-range
// positions skip the run state. A new word is taken only once the previous
// one is through, even while its result still waits. Reset: config returns
// to its defaults (snake, 8 x 8, top-left, down) and no result is pending.
module matrix_scan_order_index_to_coord #(
    parameter int MAX_DIM = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    msoic_chan_if.sink    request,
    msoic_chan_if.source  result,
    msoic_chan_if.sink    cfg
);
    import msoic_pkg::*;

    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int AW   = 2 * DW;
    localparam int CMPW = (AW > POS_W) ? AW : POS_W;

    typedef enum logic [2:0] {ST_IDLE, ST_AREA, ST_CHECK, ST_RUN, ST_FINISH} state_t;

    state_t              state_reg;
    logic [1:0]          scan_mode_reg;
    logic [8:0]          row_count_reg, col_count_reg;
    logic [1:0]          start_corner_reg, first_direction_reg;
    logic [POS_W-1:0]    pos_reg, cnt_reg;
    logic [AW-1:0]       area_reg;
    logic                oor_reg;
    logic                out_valid_reg;
    out_word_t           out_data_reg;

    logic [DW-1:0]       nr, nc, r0, c0;
    dir_t                dir0, dir_init;
    logic                blocked, sense_init, finish_load;
    walk_ctl_t           ctl;
    logic [COORD_W-1:0]  walk_row, walk_col;

    function automatic logic [DW-1:0] clamp_dim(input logic [8:0] v);
        if (v == 9'd0)
            return DW'(1);
        else if (32'(v) > MAX_DIM)
            return DW'(MAX_DIM);
        else
            return DW'(v);
    endfunction

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg       <= MODE_SNAKE;
            row_count_reg       <= 9'd8;
            col_count_reg       <= 9'd8;
            start_corner_reg    <= 2'd0;
            first_direction_reg <= DIR_DOWN;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_SCAN_MODE:       scan_mode_reg       <= cfg.data.value[1:0];
                REG_ROW_COUNT:       row_count_reg       <= cfg.data.value;
                REG_COL_COUNT:       col_count_reg       <= cfg.data.value;
                REG_START_CORNER:    start_corner_reg    <= cfg.data.value[1:0];
                REG_FIRST_DIRECTION: first_direction_reg <= cfg.data.value[1:0];
                default: ;
            endcase
        end
    end

    // start point, first direction and turning sense
    always_comb
    begin
        nr = clamp_dim(row_count_reg);
        nc = clamp_dim(col_count_reg);
        r0 = start_corner_reg[0] ? nr - DW'(1) : '0;
        c0 = start_corner_reg[1] ? nc - DW'(1) : '0;

        dir0 = '0;
        unique case (first_direction_reg)
            DIR_UP:    dir0.dr = -2'sd1;
            DIR_DOWN:  dir0.dr = 2'sd1;
            DIR_LEFT:  dir0.dc = -2'sd1;
            DIR_RIGHT: dir0.dc = 2'sd1;
            default:   dir0 = '0;
        endcase

        blocked = (dir0.dr == -2'sd1 && r0 == '0) ||
                  (dir0.dr == 2'sd1 && r0 == nr - DW'(1)) ||
                  (dir0.dc == -2'sd1 && c0 == '0) ||
                  (dir0.dc == 2'sd1 && c0 == nc - DW'(1));
        dir_init.dr = blocked ? -dir0.dr : dir0.dr;
        dir_init.dc = blocked ? -dir0.dc : dir0.dc;

        sense_init = (r0 == '0 && c0 == '0 && dir_init.dr == 2'sd1) ||
                     (r0 == '0 && c0 == nc - DW'(1) && dir_init.dc == -2'sd1) ||
                     (r0 == nr - DW'(1) && c0 == nc - DW'(1) && dir_init.dr == -2'sd1) ||
                     (r0 == nr - DW'(1) && c0 == '0 && dir_init.dc == 2'sd1);

        ctl.load      = (state_reg == ST_CHECK);
        ctl.step      = (state_reg == ST_RUN) && (cnt_reg != '0);
        ctl.spiral    = (scan_mode_reg == MODE_SPIRAL) || (scan_mode_reg == MODE_REV_SPIRAL);
        ctl.rev       = (scan_mode_reg == MODE_REV_SPIRAL);
        ctl.sense_pos = sense_init;
        ctl.dir       = dir_init;
        ctl.r0_zero   = (r0 == '0);
        ctl.c0_zero   = (c0 == '0);
    end

    msoic_walker #(.MAX_DIM(MAX_DIM)) u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .nr    (nr),
        .nc    (nc),
        .r0    (r0),
        .c0    (c0),
        .row   (walk_row),
        .col   (walk_col)
    );

    assign request.ready = (state_reg == ST_IDLE);
    assign finish_load   = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (request.valid)
                    begin
                        pos_reg   <= request.data.position;
                        state_reg <= ST_AREA;
                    end
                end
                ST_AREA:
                begin
                    area_reg  <= {{DW{1'b0}}, nr} * {{DW{1'b0}}, nc};
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    oor_reg   <= (CMPW'(pos_reg) >= CMPW'(area_reg));
                    cnt_reg   <= pos_reg;
                    state_reg <= (CMPW'(pos_reg) >= CMPW'(area_reg)) ? ST_FINISH : ST_RUN;
                end
                ST_RUN:
                begin
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - POS_W'(1);
                    else
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (finish_load)
                    begin
                        out_data_reg.row          <= oor_reg ? '0 : walk_row;
                        out_data_reg.col          <= oor_reg ? '0 : walk_col;
                        out_data_reg.out_of_range <= oor_reg;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.out_of_range |->
            result.data.row == '0 && result.data.col == '0)
        else $error("out-of-range result carries nonzero coordinates");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && cnt_reg != '0 |=>
            state_reg == ST_RUN && cnt_reg == $past(cnt_reg) - POS_W'(1))
        else $error("step counter did not advance by one");

    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=>
            state_reg == ST_AREA && pos_reg == $past(request.data.position))
        else $error("accepted word not captured");
`endif

endmodule
